/* hw/rtl/env_sensor_compensation_unit_macros.svh */
// assertion macros shared by the compensation unit checkers
`ifndef ENV_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ESC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esc assertion failed");

// next-cycle implication, disabled during reset
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esc assertion failed");

`endif

/* hw/rtl/esc_pkg.sv */
// shared types, constants and helpers of the sensor compensation unit
`timescale 1ns / 1ps
package esc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM       = 3'd4;

  // raw markers and arithmetic constants
  localparam logic [23:0] RAW24_SKIP = 24'h800000;
  localparam logic [15:0] RAW16_SKIP = 16'h8000;
  localparam logic signed [21:0] TEMP_SKIP_CENTI = -22'sd12700;
  localparam logic [31:0] HUM_OFS     = 32'd76800;
  localparam logic [31:0] HUM_ROUND   = 32'd16384;
  localparam logic [31:0] HUM_Z_OFS   = 32'd32768;
  localparam logic [31:0] HUM_W_OFS   = 32'd2097152;
  localparam logic [31:0] HUM_W_ROUND = 32'd8192;
  localparam logic [31:0] HUM_MAX     = 32'd419430400;
  localparam logic [63:0] PRESS_OFS   = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] PRESS_ONE47 = 64'h0000_8000_0000_0000;

  // pressure status codes
  localparam logic [1:0] PST_OK   = 2'd0;
  localparam logic [1:0] PST_SKIP = 2'd1;
  localparam logic [1:0] PST_ZDIV = 2'd2;
  localparam logic [1:0] PST_SAT  = 2'd3;

  typedef struct packed {
    logic [23:0] raw_temp;
    logic [23:0] raw_press;
    logic [15:0] raw_hum;
  } in_t;

  typedef struct packed {
    logic signed [21:0] temp_centi;
    logic               temp_status;
    logic [31:0]        press_q24_8;
    logic [1:0]         press_status;
    logic [16:0]        hum_q22_10;
    logic               hum_status;
  } out_t;

  // compensation steps, in issue order
  typedef enum logic [4:0] {
    SP_T1, SP_T2, SP_T3,
    SP_H1, SP_H2, SP_H3, SP_H4, SP_H5, SP_H6, SP_H7, SP_H8,
    SP_P1, SP_P2, SP_P3, SP_P4, SP_P5, SP_P6, SP_P7,
    SP_DIV, SP_P8, SP_P9, SP_P10, SP_PF, SP_DONE
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_ISSUE, ST_WAIT, ST_WB, ST_FINISH
  } state_t;

  typedef struct packed {
    logic  load;
    logic  go;
    logic  wb;
    logic  out_load;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic t_skip;
    logic h_skip;
    logic p_skip;
    logic p_zero;
    logic unit_done;
    logic out_busy;
  } status_t;

  function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] v, input logic [5:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

/* hw/rtl/esc_mul.sv */
// 64-bit wrapping multiplier, one 16-bit slice of b per cycle
`timescale 1ns / 1ps
module esc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [79:0] part;

  // partial product of the current slice
  assign part = a_r * b_r[15:0];
  assign prod = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (go) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // accumulate slices
  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      b_r <= b;
      acc <= 64'd0;
    end else if (busy) begin
      acc <= acc + part[63:0];
      a_r <= {a_r[47:0], 16'd0};
      b_r <= {16'd0, b_r[63:16]};
    end
  end

endmodule

/* hw/rtl/esc_div.sv */
// signed 64-bit truncating divider, restoring, one quotient bit per cycle
`timescale 1ns / 1ps
module esc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] md;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] rs;
  logic        ge;

  // trial subtract
  assign rs  = {rem, q[63]};
  assign ge  = rs >= {1'b0, md};
  assign quo = neg ? (64'd0 - q) : q;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= busy && (cnt == 6'd63);
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // magnitude shift and subtract
  always_ff @(posedge clk) begin
    if (go) begin
      md  <= den[63] ? (64'd0 - den) : den;
      q   <= num[63] ? (64'd0 - num) : num;
      rem <= 64'd0;
      neg <= num[63] ^ den[63];
    end else if (busy) begin
      rem <= ge ? 64'(rs - {1'b0, md}) : rs[63:0];
      q   <= {q[62:0], ge};
    end
  end

endmodule

/* hw/rtl/esc_datapath.sv */
// compensation datapath: config registers, working registers, shared units
`timescale 1ns / 1ps
module esc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  esc_pkg::in_t                      in_data,
  output esc_pkg::out_t                     out_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  esc_pkg::cmd_t                     cmd,
  output esc_pkg::status_t                  status
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;
  logic [63:0] hum_coeffs;
  logic [25:0] fine_temp;

  esc_pkg::in_t raw;
  logic        t_skip, h_skip, p_skip, p_zero;
  logic [63:0] r1, r2, r3, r4, pp;
  logic [16:0] hval;
  logic [31:0] pval;
  logic [1:0]  pstat;

  logic [63:0] opa, opb;
  logic        mul_go, div_go, mul_done, div_done;
  logic [63:0] prod, div_q;
  logic [31:0] prod32;

  // coefficient fields
  logic [63:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h5, h6;
  logic [31:0] h4;
  assign t1 = {48'd0, temp_coeffs[15:0]};
  assign t2 = esc_pkg::sx16(temp_coeffs[31:16]);
  assign t3 = esc_pkg::sx16(temp_coeffs[47:32]);
  assign p1 = {48'd0, press_coeffs_low[15:0]};
  assign p2 = esc_pkg::sx16(press_coeffs_low[31:16]);
  assign p3 = esc_pkg::sx16(press_coeffs_low[47:32]);
  assign p4 = esc_pkg::sx16(press_coeffs_low[63:48]);
  assign p5 = esc_pkg::sx16(press_coeffs_high[15:0]);
  assign p6 = esc_pkg::sx16(press_coeffs_high[31:16]);
  assign p7 = esc_pkg::sx16(press_coeffs_high[47:32]);
  assign p8 = esc_pkg::sx16(press_coeffs_high[63:48]);
  assign p9 = esc_pkg::sx16(press_coeff_nine);
  assign h1 = {56'd0, hum_coeffs[7:0]};
  assign h2 = esc_pkg::sx16(hum_coeffs[23:8]);
  assign h3 = {56'd0, hum_coeffs[31:24]};
  assign h4 = {{20{hum_coeffs[43]}}, hum_coeffs[43:32]};
  assign h5 = {{52{hum_coeffs[55]}}, hum_coeffs[55:44]};
  assign h6 = {{56{hum_coeffs[63]}}, hum_coeffs[63:56]};

  // derived inputs
  logic [31:0] ft32, hv, t_a, t_d, hq;
  logic [63:0] pa0, s_val, p_base;
  assign ft32   = {{6{fine_temp[25]}}, fine_temp};
  assign hv     = ft32 - esc_pkg::HUM_OFS;
  assign pa0    = esc_pkg::sx32(ft32) - esc_pkg::PRESS_OFS;
  assign t_a    = {15'd0, raw.raw_temp[23:7]} - {15'd0, t1[15:0], 1'b0};
  assign t_d    = {16'd0, raw.raw_temp[23:8]} - t1[31:0];
  assign hq     = esc_pkg::sra32(r1[31:0], 5'd15);
  assign s_val  = esc_pkg::sra64(pp, 6'd13);
  assign p_base = esc_pkg::PRESS_BASE - {44'd0, raw.raw_press[23:4]};
  assign prod32 = prod[31:0];

  // operand select per step
  always_comb begin
    opa = 64'd0;
    opb = 64'd0;
    case (cmd.step)
      esc_pkg::SP_T1:  begin opa = esc_pkg::sx32(t_a);        opb = t2; end
      esc_pkg::SP_T2:  begin opa = esc_pkg::sx32(t_d);        opb = esc_pkg::sx32(t_d); end
      esc_pkg::SP_T3:  begin opa = esc_pkg::sx32(r2[31:0]);   opb = t3; end
      esc_pkg::SP_H1:  begin opa = h5;                        opb = esc_pkg::sx32(hv); end
      esc_pkg::SP_H2:  begin opa = esc_pkg::sx32(hv);         opb = h6; end
      esc_pkg::SP_H3:  begin opa = esc_pkg::sx32(hv);         opb = h3; end
      esc_pkg::SP_H4:  begin opa = esc_pkg::sx32(r2[31:0]);   opb = esc_pkg::sx32(r3[31:0]); end
      esc_pkg::SP_H5:  begin opa = esc_pkg::sx32(r4[31:0]);   opb = h2; end
      esc_pkg::SP_H6:  begin opa = esc_pkg::sx32(r1[31:0]);   opb = esc_pkg::sx32(r4[31:0]); end
      esc_pkg::SP_H7:  begin opa = esc_pkg::sx32(hq);         opb = esc_pkg::sx32(hq); end
      esc_pkg::SP_H8:  begin opa = esc_pkg::sx32(r2[31:0]);   opb = h1; end
      esc_pkg::SP_P1:  begin opa = pa0;                       opb = pa0; end
      esc_pkg::SP_P2:  begin opa = r2;                        opb = p6; end
      esc_pkg::SP_P3:  begin opa = r1;                        opb = p5; end
      esc_pkg::SP_P4:  begin opa = r2;                        opb = p3; end
      esc_pkg::SP_P5:  begin opa = r1;                        opb = p2; end
      esc_pkg::SP_P6:  begin opa = esc_pkg::PRESS_ONE47 + r1; opb = p1; end
      esc_pkg::SP_P7:  begin opa = {p_base[32:0], 31'd0} - r3; opb = esc_pkg::PRESS_SCALE; end
      esc_pkg::SP_P8:  begin opa = p9;                        opb = s_val; end
      esc_pkg::SP_P9:  begin opa = r3;                        opb = s_val; end
      esc_pkg::SP_P10: begin opa = p8;                        opb = pp; end
      default: begin
        opa = 64'd0;
        opb = 64'd0;
      end
    endcase
  end

  assign div_go = cmd.go && (cmd.step == esc_pkg::SP_DIV);
  assign mul_go = cmd.go && (cmd.step != esc_pkg::SP_DIV);

  esc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (opa),
    .b    (opb),
    .done (mul_done),
    .prod (prod)
  );

  esc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (r2),
    .den  (r1),
    .done (div_done),
    .quo  (div_q)
  );

  // write-back values that need more than a shift
  logic [31:0] h_x, h_v, h_c;
  logic [63:0] p_a, p_f;
  always_comb begin
    h_x = esc_pkg::sra32({2'd0, raw.raw_hum, 14'd0} - {h4[11:0], 20'd0} - prod32
                         + esc_pkg::HUM_ROUND, 5'd15);
    h_v = r1[31:0] - esc_pkg::sra32(prod32, 5'd4);
    h_c = h_v;
    if (h_v[31]) begin
      h_c = 32'd0;
    end else if (h_v > esc_pkg::HUM_MAX) begin
      h_c = esc_pkg::HUM_MAX;
    end
    p_a = esc_pkg::sra64(prod, 6'd33);
    p_f = esc_pkg::sra64(pp + r3 + r4, 6'd8) + {p7[59:0], 4'd0};
  end

  // temperature in hundredths, from the current fine temperature
  logic [31:0] tc32;
  logic signed [21:0] tcent;
  assign tc32  = esc_pkg::sra32({ft32[29:0], 2'd0} + ft32 + 32'd128, 5'd8);
  assign tcent = t_skip ? esc_pkg::TEMP_SKIP_CENTI : $signed(tc32[21:0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= 48'd0;
      press_coeffs_low  <= 64'd0;
      press_coeffs_high <= 64'd0;
      press_coeff_nine  <= 16'd0;
      hum_coeffs        <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::CFG_TEMP:      temp_coeffs       <= cfg_data[47:0];
        esc_pkg::CFG_PRESS_LOW: press_coeffs_low  <= cfg_data;
        esc_pkg::CFG_PRESS_HI:  press_coeffs_high <= cfg_data;
        esc_pkg::CFG_PRESS_P9:  press_coeff_nine  <= cfg_data[15:0];
        esc_pkg::CFG_HUM:       hum_coeffs        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // fine temperature and skip flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_temp <= 26'd0;
      t_skip    <= 1'b0;
      h_skip    <= 1'b0;
      p_skip    <= 1'b0;
      p_zero    <= 1'b0;
    end else if (cmd.load) begin
      t_skip <= in_data.raw_temp == esc_pkg::RAW24_SKIP;
      h_skip <= in_data.raw_hum == esc_pkg::RAW16_SKIP;
      p_skip <= in_data.raw_press == esc_pkg::RAW24_SKIP;
      p_zero <= 1'b0;
    end else if (cmd.wb) begin
      if (cmd.step == esc_pkg::SP_T3) begin
        fine_temp <= 26'(r1[31:0] + esc_pkg::sra32(prod32, 5'd14));
      end
      if (cmd.step == esc_pkg::SP_P6) begin
        p_zero <= p_a == 64'd0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw   <= in_data;
      hval  <= 17'd0;
      pval  <= 32'd0;
      pstat <= (in_data.raw_press == esc_pkg::RAW24_SKIP) ? esc_pkg::PST_SKIP
                                                         : esc_pkg::PST_OK;
    end else if (cmd.go && cmd.step == esc_pkg::SP_P1) begin
      r1 <= pa0;
    end else if (cmd.wb) begin
      case (cmd.step)
        esc_pkg::SP_T1:  r1[31:0] <= esc_pkg::sra32(prod32, 5'd11);
        esc_pkg::SP_T2:  r2[31:0] <= esc_pkg::sra32(prod32, 5'd12);
        esc_pkg::SP_H1:  r1[31:0] <= h_x;
        esc_pkg::SP_H2:  r2[31:0] <= esc_pkg::sra32(prod32, 5'd10);
        esc_pkg::SP_H3:  r3[31:0] <= esc_pkg::sra32(prod32, 5'd11) + esc_pkg::HUM_Z_OFS;
        esc_pkg::SP_H4:  r4[31:0] <= esc_pkg::sra32(prod32, 5'd10) + esc_pkg::HUM_W_OFS;
        esc_pkg::SP_H5:  r4[31:0] <= esc_pkg::sra32(prod32 + esc_pkg::HUM_W_ROUND, 5'd14);
        esc_pkg::SP_H6:  r1[31:0] <= prod32;
        esc_pkg::SP_H7:  r2[31:0] <= esc_pkg::sra32(prod32, 5'd7);
        esc_pkg::SP_H8:  hval <= h_c[28:12];
        esc_pkg::SP_P1:  r2 <= prod;
        esc_pkg::SP_P2:  r3 <= prod;
        esc_pkg::SP_P3:  r3 <= r3 + {prod[46:0], 17'd0} + {p4[28:0], 35'd0};
        esc_pkg::SP_P4:  r4 <= esc_pkg::sra64(prod, 6'd8);
        esc_pkg::SP_P5:  r1 <= r4 + {prod[51:0], 12'd0};
        esc_pkg::SP_P6: begin
          r1 <= p_a;
          if (p_a == 64'd0) begin
            pstat <= esc_pkg::PST_ZDIV;
          end
        end
        esc_pkg::SP_P7:  r2 <= prod;
        esc_pkg::SP_DIV: pp <= div_q;
        esc_pkg::SP_P8:  r3 <= prod;
        esc_pkg::SP_P9:  r3 <= esc_pkg::sra64(prod, 6'd25);
        esc_pkg::SP_P10: r4 <= esc_pkg::sra64(prod, 6'd19);
        esc_pkg::SP_PF: begin
          if (p_f[63]) begin
            pval  <= 32'd0;
            pstat <= esc_pkg::PST_SAT;
          end else if (p_f[62:32] != 31'd0) begin
            pval  <= 32'hFFFF_FFFF;
            pstat <= esc_pkg::PST_SAT;
          end else begin
            pval  <= p_f[31:0];
            pstat <= esc_pkg::PST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.temp_centi   <= tcent;
      out_data.temp_status  <= t_skip;
      out_data.press_q24_8  <= pval;
      out_data.press_status <= pstat;
      out_data.hum_q22_10   <= hval;
      out_data.hum_status   <= h_skip;
    end
  end

  // status to the controller
  assign status.t_skip    = t_skip;
  assign status.h_skip    = h_skip;
  assign status.p_skip    = p_skip;
  assign status.p_zero    = p_zero;
  assign status.unit_done = mul_done || div_done;
  assign status.out_busy  = out_valid && !out_ready;

endmodule

/* hw/rtl/esc_ctrl.sv */
// compensation sequencer: walks the step list and drives the datapath
`timescale 1ns / 1ps
module esc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output esc_pkg::cmd_t     cmd,
  input  esc_pkg::status_t  status
);

  esc_pkg::state_t state, state_next;
  esc_pkg::step_t  step;
  logic            step_skip;

  // steps whose reading was skipped or whose divisor is zero
  always_comb begin
    step_skip = 1'b0;
    if (step <= esc_pkg::SP_T3) begin
      step_skip = status.t_skip;
    end else if (step >= esc_pkg::SP_H1 && step <= esc_pkg::SP_H8) begin
      step_skip = status.h_skip;
    end else if (step >= esc_pkg::SP_P1 && step <= esc_pkg::SP_P6) begin
      step_skip = status.p_skip;
    end else if (step >= esc_pkg::SP_P7 && step <= esc_pkg::SP_PF) begin
      step_skip = status.p_skip || status.p_zero;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      esc_pkg::ST_IDLE: begin
        if (in_valid) state_next = esc_pkg::ST_CHECK;
      end
      esc_pkg::ST_CHECK: begin
        if (step == esc_pkg::SP_DONE) begin
          state_next = esc_pkg::ST_FINISH;
        end else if (step_skip) begin
          state_next = esc_pkg::ST_CHECK;
        end else if (step == esc_pkg::SP_PF) begin
          state_next = esc_pkg::ST_WB;
        end else begin
          state_next = esc_pkg::ST_ISSUE;
        end
      end
      esc_pkg::ST_ISSUE: state_next = esc_pkg::ST_WAIT;
      esc_pkg::ST_WAIT: begin
        if (status.unit_done) state_next = esc_pkg::ST_WB;
      end
      esc_pkg::ST_WB: state_next = esc_pkg::ST_CHECK;
      esc_pkg::ST_FINISH: begin
        if (!status.out_busy) state_next = esc_pkg::ST_IDLE;
      end
      default: state_next = esc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = state == esc_pkg::ST_IDLE;
    cmd.load     = (state == esc_pkg::ST_IDLE) && in_valid;
    cmd.go       = state == esc_pkg::ST_ISSUE;
    cmd.wb       = state == esc_pkg::ST_WB;
    cmd.out_load = (state == esc_pkg::ST_FINISH) && !status.out_busy;
    cmd.step     = step;
  end

  // state and step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esc_pkg::ST_IDLE;
      step  <= esc_pkg::SP_T1;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step <= esc_pkg::SP_T1;
      end else if (cmd.wb || (state == esc_pkg::ST_CHECK && step_skip
                              && step != esc_pkg::SP_DONE)) begin
        step <= esc_pkg::step_t'(step + 5'd1);
      end
    end
  end

endmodule

/* hw/rtl/env_sensor_compensation_unit.sv */
// A full reading set takes 21 multiplies on the shared 16-bit-slice multiplier and one divide,
// plus sequencing steps; skipped readings shorten it. One item at a time: the result is loaded
// into the output register once the output is free, and the next input beat can be taken in the
// cycle after that load.
// Reset (rst, synchronous): clears coefficients, fine temperature, sequencer and output valid.
`timescale 1ns / 1ps
module env_sensor_compensation_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  esc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output esc_pkg::out_t                  out_data
);

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t status;

  // sequencer
  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic and storage
  esc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* hw/rtl/esc_checker.sv */
// port-level checks of the compensation unit, bound to the top level
`timescale 1ns / 1ps
`include "env_sensor_compensation_unit_macros.svh"
module esc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input esc_pkg::out_t out_data
);

  logic temp_skip_seen;
  logic press_err_seen;

  // result beats that carry a marker or error status
  assign temp_skip_seen = out_valid && out_data.temp_status;
  assign press_err_seen = out_valid && (out_data.press_status == esc_pkg::PST_SKIP ||
                                        out_data.press_status == esc_pkg::PST_ZDIV);

  // a stalled result beat holds
  `ESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item in flight: no input beat right after one is taken
  `ESC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // skipped temperature reports the marker value
  `ESC_ASSERT_IMPL(a_temp_skip, temp_skip_seen, out_data.temp_centi == esc_pkg::TEMP_SKIP_CENTI)

  // pressure errors report zero
  `ESC_ASSERT_IMPL(a_press_err, press_err_seen, out_data.press_q24_8 == 32'd0)

endmodule

bind env_sensor_compensation_unit esc_checker u_esc_checker (.*);
